// ----- rtl/core/arfc_pkg.sv -----
package arfc_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_END     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FRAME_ERR = 2'd2,
    ST_CSUM_ERR  = 2'd3
  } status_t;

  localparam logic [7:0]  CH_START    = 8'h40;
  localparam logic [7:0]  CH_STAR     = 8'h2A;
  localparam logic [7:0]  CH_CR       = 8'h0D;
  localparam logic [7:0]  CH_ZERO     = 8'h30;
  localparam logic [7:0]  CH_NINE     = 8'h39;
  localparam logic [15:0] CMD_MB      = 16'h4D42;
  localparam logic [14:0] LIMIT_RESET = 15'd40;
  localparam logic [13:0] COUNT_MAX   = 14'd10000;
  localparam logic [7:0]  BYTE_CNT_MAX = 8'd255;
  localparam logic [7:0]  MIN_FRAME   = 8'd5;
  localparam int          NUM_DIGITS  = 15;
  localparam int          DIGIT_FIRST = 5;
  localparam int          FIFO_DEPTH  = 2;
  localparam int          LIMIT_W     = 15;
  localparam int          COUNT_W     = 14;

  typedef logic [3:0] digit_t;

  // One closed frame or timeout, handed from the front to the back.
  typedef struct packed {
    logic                         is_timeout;
    status_t                      status;
    logic                         fields_valid;
    digit_t [NUM_DIGITS-1:0]      digits;
  } evt_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v >= 4'd10) begin
      c = 8'h41 + {4'd0, v} - 8'd10;
    end else begin
      c = CH_ZERO + {4'd0, v};
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/arfc_front.sv -----
module arfc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_tuser,
  input  logic [7:0]         in_tdata,
  input  logic               fifo_full,
  output logic               push,
  output arfc_pkg::evt_t     evt
);
  import arfc_pkg::*;

  logic [7:0]              byte_cnt_r,  byte_cnt_nxt;
  logic [7:0]              xor_r,       xor_nxt;
  logic [3:0][7:0]         tail_r,      tail_nxt;
  logic [7:0]              first_r,     first_nxt;
  logic [15:0]             cmd_chars_r, cmd_chars_nxt;
  digit_t [NUM_DIGITS-1:0] digit_r,     digit_nxt;

  cmd_t       cmd;
  logic       acc;
  logic [7:0] chk;
  digit_t     dval;
  status_t    status;

  assign in_tready = !fifo_full;
  assign acc       = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign push      = acc && (cmd == CMD_END || cmd == CMD_TIMEOUT);

  // Non-digit characters count as zero.
  assign dval = (in_tdata >= CH_ZERO && in_tdata <= CH_NINE) ? in_tdata[3:0] : 4'd0;

  // XOR over everything but the last four bytes.
  assign chk = xor_r ^ tail_r[0] ^ tail_r[1] ^ tail_r[2] ^ tail_r[3];

  always_comb begin
    if (cmd == CMD_TIMEOUT || byte_cnt_r == 8'd0) begin
      status = ST_EMPTY;
    end else if (byte_cnt_r < MIN_FRAME || first_r != CH_START ||
                 tail_r[1] != CH_STAR || tail_r[0] != CH_CR) begin
      status = ST_FRAME_ERR;
    end else if (hex_char(chk[7:4]) != tail_r[3] || hex_char(chk[3:0]) != tail_r[2]) begin
      status = ST_CSUM_ERR;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    evt.is_timeout   = (cmd == CMD_TIMEOUT);
    evt.status       = status;
    evt.fields_valid = (status == ST_OK) && (cmd_chars_r != CMD_MB);
    evt.digits       = digit_r;
  end

  always_comb begin
    byte_cnt_nxt  = byte_cnt_r;
    xor_nxt       = xor_r;
    tail_nxt      = tail_r;
    first_nxt     = first_r;
    cmd_chars_nxt = cmd_chars_r;
    digit_nxt     = digit_r;
    if (acc) begin
      unique case (cmd)
        CMD_BYTE: begin
          if (byte_cnt_r == 8'd0) first_nxt = in_tdata;
          if (byte_cnt_r == 8'd3) cmd_chars_nxt[15:8] = in_tdata;
          if (byte_cnt_r == 8'd4) cmd_chars_nxt[7:0] = in_tdata;
          for (int i = 0; i < NUM_DIGITS; i++) begin
            if (byte_cnt_r == 8'(DIGIT_FIRST + i)) digit_nxt[i] = dval;
          end
          xor_nxt  = xor_r ^ in_tdata;
          tail_nxt = {tail_r[2:0], in_tdata};
          if (byte_cnt_r != BYTE_CNT_MAX) byte_cnt_nxt = byte_cnt_r + 8'd1;
        end
        CMD_END, CMD_TIMEOUT: begin
          // Drop the frame state once the word is queued.
          byte_cnt_nxt  = '0;
          xor_nxt       = '0;
          tail_nxt      = '0;
          first_nxt     = '0;
          cmd_chars_nxt = '0;
          digit_nxt     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      xor_r       <= '0;
      tail_r      <= '0;
      first_r     <= '0;
      cmd_chars_r <= '0;
      digit_r     <= '0;
    end else begin
      byte_cnt_r  <= byte_cnt_nxt;
      xor_r       <= xor_nxt;
      tail_r      <= tail_nxt;
      first_r     <= first_nxt;
      cmd_chars_r <= cmd_chars_nxt;
      digit_r     <= digit_nxt;
    end
  end

endmodule

// ----- rtl/core/arfc_fifo.sv -----
module arfc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  arfc_pkg::evt_t     push_evt,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output arfc_pkg::evt_t     pop_evt
);
  import arfc_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  evt_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full      = (count_r == CNT_W'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_evt   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/arfc_back.sv -----
module arfc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [arfc_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                          evt_valid,
  input  arfc_pkg::evt_t                evt,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [1:0]                    status,
  output logic                          fields_valid,
  output logic [6:0]                    comm_fault_code,
  output logic [3:0]                    power_is_on,
  output logic [3:0]                    cc_or_cv,
  output logic [3:0]                    auto_or_manual,
  output logic [6:0]                    local_fault_code,
  output logic [13:0]                   actual_current,
  output logic [13:0]                   actual_voltage,
  output logic [13:0]                   timeout_total,
  output logic [13:0]                   error_total,
  output logic                          over_limit
);
  import arfc_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic [COUNT_W-1:0] to_cnt_r,  to_cnt_nxt;
  logic [COUNT_W-1:0] err_cnt_r, err_cnt_nxt;
  logic               out_valid_r;
  logic [LIMIT_W-1:0] sum;

  logic [1:0]  status_r;
  logic        fv_r;
  logic [6:0]  comm_r,  comm_nxt;
  logic [3:0]  power_r, cc_r, auto_r;
  logic [6:0]  local_r, local_nxt;
  logic [13:0] cur_r,   cur_nxt;
  logic [13:0] volt_r,  volt_nxt;
  logic        over_r;

  digit_t [NUM_DIGITS-1:0] d;

  assign d   = evt.digits;
  assign pop = evt_valid && (!out_valid_r || out_tready);

  always_comb begin
    to_cnt_nxt  = to_cnt_r;
    err_cnt_nxt = err_cnt_r;
    if (evt.is_timeout) begin
      if (to_cnt_r < COUNT_MAX) to_cnt_nxt = to_cnt_r + 1'b1;
    end else begin
      unique case (evt.status)
        ST_OK: begin
          to_cnt_nxt  = '0;
          err_cnt_nxt = '0;
        end
        ST_FRAME_ERR, ST_CSUM_ERR: begin
          if (err_cnt_r < COUNT_MAX) err_cnt_nxt = err_cnt_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign sum = {1'b0, to_cnt_nxt} + {1'b0, err_cnt_nxt};

  always_comb begin
    comm_nxt  = 7'(d[0]) * 7'd10 + 7'(d[1]);
    local_nxt = 7'(d[5]) * 7'd10 + 7'(d[6]);
    cur_nxt   = 14'(d[7]) * 14'd1000 + 14'(d[8]) * 14'd100 + 14'(d[9]) * 14'd10
              + 14'(d[10]);
    volt_nxt  = 14'(d[11]) * 14'd1000 + 14'(d[12]) * 14'd100 + 14'(d[13]) * 14'd10
              + 14'(d[14]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      to_cnt_r    <= '0;
      err_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) limit_r <= cfg_data;
      if (pop) begin
        to_cnt_r  <= to_cnt_nxt;
        err_cnt_r <= err_cnt_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result word until taken; zero the decoded fields when not valid.
  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= evt.status;
      fv_r     <= evt.fields_valid;
      comm_r   <= evt.fields_valid ? comm_nxt  : '0;
      power_r  <= evt.fields_valid ? d[2]      : '0;
      cc_r     <= evt.fields_valid ? d[3]      : '0;
      auto_r   <= evt.fields_valid ? d[4]      : '0;
      local_r  <= evt.fields_valid ? local_nxt : '0;
      cur_r    <= evt.fields_valid ? cur_nxt   : '0;
      volt_r   <= evt.fields_valid ? volt_nxt  : '0;
      over_r   <= (sum > limit_r);
    end
  end

  assign out_tvalid       = out_valid_r;
  assign status           = status_r;
  assign fields_valid     = fv_r;
  assign comm_fault_code  = comm_r;
  assign power_is_on      = power_r;
  assign cc_or_cv         = cc_r;
  assign auto_or_manual   = auto_r;
  assign local_fault_code = local_r;
  assign actual_current   = cur_r;
  assign actual_voltage   = volt_r;
  assign timeout_total    = to_cnt_r;
  assign error_total      = err_cnt_r;
  assign over_limit       = over_r;

endmodule

// ----- rtl/core/ascii_reply_frame_checker.sv -----
// Channel  Ports                     Contents
// in       in_tvalid/tready/tuser    tuser = command, tdata = data_byte
//          in_tdata
// out      out_tvalid/tready/tuser   tuser = status, fields_valid; tdata = decoded
//          out_tdata                 fields, counters and over_limit
// cfg      cfg_valid/ready/data      fault_sum_limit, always ready
//
// One word per cycle in while the queue has room; a frame end or timeout gives one
// result word, passed through a two-entry event queue and then the output register.
// Received bytes give no result and only update the front's frame state.
// Reset (rst_n low, synchronous) clears frame state, counters and queue and sets
// the limit to 40. A stalled output backs up the queue; in_tready drops only
// when the queue is full.
module ascii_reply_frame_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // [1:0] command
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [2:0]   out_tuser,  // [1:0] status, [2] fields_valid
  output logic [87:0]  out_tdata,  // [6:0] comm_fault_code, [10:7] power_is_on,
                                   // [14:11] cc_or_cv, [18:15] auto_or_manual,
                                   // [25:19] local_fault_code, [39:26] actual_current,
                                   // [53:40] actual_voltage, [67:54] timeout_total,
                                   // [81:68] error_total, [82] over_limit, rest zero
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [14:0]  cfg_data
);
  import arfc_pkg::*;

  evt_t        push_evt, pop_evt;
  logic        push, pop, full, not_empty;
  logic [1:0]  status;
  logic        fields_valid;
  logic [6:0]  comm_fault_code, local_fault_code;
  logic [3:0]  power_is_on, cc_or_cv, auto_or_manual;
  logic [13:0] actual_current, actual_voltage, timeout_total, error_total;
  logic        over_limit;

  assign cfg_ready = 1'b1;

  arfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .fifo_full (full),
    .push      (push),
    .evt       (push_evt)
  );

  arfc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_evt  (push_evt),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_evt   (pop_evt)
  );

  arfc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .evt_valid        (not_empty),
    .evt              (pop_evt),
    .pop              (pop),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .status           (status),
    .fields_valid     (fields_valid),
    .comm_fault_code  (comm_fault_code),
    .power_is_on      (power_is_on),
    .cc_or_cv         (cc_or_cv),
    .auto_or_manual   (auto_or_manual),
    .local_fault_code (local_fault_code),
    .actual_current   (actual_current),
    .actual_voltage   (actual_voltage),
    .timeout_total    (timeout_total),
    .error_total      (error_total),
    .over_limit       (over_limit)
  );

  assign out_tuser = {fields_valid, status};
  assign out_tdata = {5'd0, over_limit, error_total, timeout_total, actual_voltage,
                      actual_current, local_fault_code, auto_or_manual, cc_or_cv,
                      power_is_on, comm_fault_code};

endmodule

// ----- rtl/core/arfc_checker.sv -----
module arfc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [2:0]   out_tuser,
  input logic [87:0]  out_tdata
);
  import arfc_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Decoded fields only come with a good frame.
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == ST_OK)
    else $error("fields_valid without good status");

  // A good frame clears both counters.
  a_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ST_OK |-> out_tdata[81:54] == '0)
    else $error("counters not cleared on good frame");

  // Undecoded words carry zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tdata[53:0] == '0)
    else $error("decoded fields nonzero without fields_valid");

endmodule

bind ascii_reply_frame_checker arfc_checker u_arfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

// ----- tb/ascii_reply_frame_checker_test.sv -----
module ascii_reply_frame_checker_test;
  import arfc_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int IDLE_SETTLE = 8;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    FLAW_NONE,
    FLAW_START,
    FLAW_SUM,
    FLAW_CASE,
    FLAW_TAIL
  } flaw_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } word_t;

  // Same bit order as {out_tuser, out_tdata}.
  typedef struct packed {
    logic        fields_valid;
    logic [1:0]  status;
    logic [4:0]  pad;
    logic        over_limit;
    logic [13:0] error_total;
    logic [13:0] timeout_total;
    logic [13:0] voltage;
    logic [13:0] current;
    logic [6:0]  local_fault;
    logic [3:0]  auto_manual;
    logic [3:0]  cc_cv;
    logic [3:0]  power_on;
    logic [6:0]  comm_fault;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = CMD_NONE;   // [1:0] command
  logic [7:0]  in_tdata = '0;         // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;             // [1:0] status, [2] fields_valid
  logic [87:0] out_tdata;             // comm_fault_code .. over_limit, rest zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [14:0] cfg_data = '0;

  ascii_reply_frame_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Frame tracking, counter and limit state of the predictor
  logic [7:0]        frm_len = '0;
  logic [7:0]        frm_xor = '0;
  logic [3:0][7:0]   frm_tail = '0;
  logic [7:0]        frm_first = '0;
  logic [15:0]       frm_cmd = '0;
  logic [3:0]        frm_digits [NUM_DIGITS];
  logic [13:0]       tmo_total = '0;
  logic [13:0]       err_total = '0;
  logic [14:0]       fault_limit = LIMIT_RESET;

  word_t       pend_q[$];
  reply_t      pending_replies[$];
  word_t       drv_word;
  int          word_total = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  logic        in_took = 1'b0;
  logic        out_took = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] hex_up(input logic [3:0] n);
    return (n < 4'd10) ? CH_ZERO + n : "A" + n - 10;
  endfunction

  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic void clear_frame();
    frm_len   = '0;
    frm_xor   = '0;
    frm_tail  = '0;
    frm_first = '0;
    frm_cmd   = '0;
    foreach (frm_digits[i]) frm_digits[i] = '0;
  endfunction

  initial clear_frame();

  // Absorb one accepted word; frame ends and timeouts queue the reply they cause.
  function automatic void reply_for_word(input cmd_t cmd, input logic [7:0] b);
    reply_t     r;
    logic [7:0] chk;
    status_t    st;
    if (cmd == CMD_NONE) return;
    if (cmd == CMD_BYTE) begin
      if (frm_len == 8'd0) frm_first = b;
      else if (frm_len == 8'd3) frm_cmd[15:8] = b;
      else if (frm_len == 8'd4) frm_cmd[7:0] = b;
      else if (frm_len >= DIGIT_FIRST && frm_len < DIGIT_FIRST + NUM_DIGITS)
        frm_digits[frm_len - DIGIT_FIRST] = (b >= CH_ZERO && b <= CH_NINE) ? b - CH_ZERO : 4'd0;
      frm_xor  = frm_xor ^ b;
      frm_tail = {frm_tail[2:0], b};
      if (frm_len != BYTE_CNT_MAX) frm_len = frm_len + 8'd1;
      return;
    end
    r = '0;
    if (cmd == CMD_TIMEOUT) begin
      if (tmo_total < COUNT_MAX) tmo_total = tmo_total + 14'd1;
      st = ST_EMPTY;
    end else if (frm_len == 8'd0) begin
      st = ST_EMPTY;
    end else begin
      chk = frm_xor ^ frm_tail[0] ^ frm_tail[1] ^ frm_tail[2] ^ frm_tail[3];
      if (frm_len < MIN_FRAME || frm_first != CH_START || frm_tail[1] != CH_STAR ||
          frm_tail[0] != CH_CR) begin
        st = ST_FRAME_ERR;
      end else if (frm_tail[3] != hex_up(chk[7:4]) || frm_tail[2] != hex_up(chk[3:0])) begin
        st = ST_CSUM_ERR;
      end else begin
        st = ST_OK;
      end
      if (st == ST_OK) begin
        tmo_total = '0;
        err_total = '0;
        r.fields_valid = (frm_cmd != CMD_MB);
      end else if (err_total < COUNT_MAX) begin
        err_total = err_total + 14'd1;
      end
    end
    r.status = st;
    if (r.fields_valid) begin
      r.comm_fault  = frm_digits[0] * 10 + frm_digits[1];
      r.power_on    = frm_digits[2];
      r.cc_cv       = frm_digits[3];
      r.auto_manual = frm_digits[4];
      r.local_fault = frm_digits[5] * 10 + frm_digits[6];
      r.current     = frm_digits[7] * 1000 + frm_digits[8] * 100 + frm_digits[9] * 10
                      + frm_digits[10];
      r.voltage     = frm_digits[11] * 1000 + frm_digits[12] * 100 + frm_digits[13] * 10
                      + frm_digits[14];
    end
    r.timeout_total = tmo_total;
    r.error_total   = err_total;
    r.over_limit    = (int'(tmo_total) + int'(err_total)) > int'(fault_limit);
    pending_replies.push_back(r);
    clear_frame();
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0d: %s", cycle_count, msg);
  endfunction

  function automatic string fld(input string n, input logic [31:0] e, input logic [31:0] a);
    return (e !== a) ? $sformatf(" %s %0d/%0d", n, e, a) : "";
  endfunction

  function automatic void check_reply();
    reply_t got;
    reply_t want;
    string  diffs;
    got = {out_tuser, out_tdata};
    if (pending_replies.size() == 0) begin
      note_failure($sformatf("result word with none expected: %h", got));
      return;
    end
    want  = pending_replies.pop_front();
    diffs = {fld("status", want.status, got.status),
             fld("fields_valid", want.fields_valid, got.fields_valid),
             fld("comm_fault_code", want.comm_fault, got.comm_fault),
             fld("power_is_on", want.power_on, got.power_on),
             fld("cc_or_cv", want.cc_cv, got.cc_cv),
             fld("auto_or_manual", want.auto_manual, got.auto_manual),
             fld("local_fault_code", want.local_fault, got.local_fault),
             fld("actual_current", want.current, got.current),
             fld("actual_voltage", want.voltage, got.voltage),
             fld("timeout_total", want.timeout_total, got.timeout_total),
             fld("error_total", want.error_total, got.error_total),
             fld("over_limit", want.over_limit, got.over_limit),
             fld("tdata pad", want.pad, got.pad)};
    if (diffs != "") note_failure({"result mismatch (expected/actual):", diffs});
  endfunction

  // Sample both channels and the config port at the rising edge
  always @(posedge clk) begin
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && cfg_valid && cfg_ready) fault_limit = cfg_data;
    if (rst_n && in_tvalid && in_tready) reply_for_word(cmd_t'(in_tuser), in_tdata);
    if (rst_n && out_tvalid && out_tready) check_reply();
  end

  // Input driver: hold the word until taken, then wait out the drawn gap
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        drv_word = pend_q.pop_front();
        in_tuser  <= drv_word.cmd;
        in_tdata  <= drv_word.data;
        in_tvalid <= 1'b1;
        in_gap = draw_gap(in_quiet);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: stall for a drawn number of cycles after each result word
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) out_gap = draw_gap(out_quiet);
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_word(input cmd_t cmd, input logic [7:0] data);
    pend_q.push_back('{cmd, data});
    if (cmd != CMD_NONE) word_total++;
  endtask

  task automatic push_frame(input int body_len, input bit mb, input flaw_t flaw);
    logic [7:0] fb[$];
    logic [7:0] x;
    logic [7:0] c;
    int         n;
    fb.push_back(CH_START);
    for (int i = 1; i < body_len; i++) begin
      if (i == 3 && mb) c = CMD_MB[15:8];
      else if (i == 4 && mb) c = CMD_MB[7:0];
      else if (i >= DIGIT_FIRST && $urandom_range(0, 9) != 0) c = CH_ZERO + $urandom_range(0, 9);
      else c = $urandom;
      fb.push_back(c);
    end
    x = '0;
    foreach (fb[k]) x ^= fb[k];
    fb.push_back(hex_up(x[7:4]));
    fb.push_back(hex_up(x[3:0]));
    fb.push_back(CH_STAR);
    fb.push_back(CH_CR);
    n = fb.size();
    case (flaw)
      FLAW_START: fb[0] = CH_START ^ ($urandom_range(1, 255));
      FLAW_SUM:   fb[n - 3 - $urandom_range(0, 1)] ^= 8'd1 << $urandom_range(0, 7);
      FLAW_CASE: begin
        // lowercase hex letters are not accepted
        fb[n - 4] |= 8'h20;
        fb[n - 3] |= 8'h20;
      end
      FLAW_TAIL:  fb[n - 1 - $urandom_range(0, 1)] = $urandom;
      default: ;
    endcase
    foreach (fb[k]) begin
      if ($urandom_range(0, 49) == 0) push_word(CMD_NONE, $urandom);
      push_word(CMD_BYTE, fb[k]);
    end
    push_word(CMD_END, $urandom);
  endtask

  task automatic fill_random(input int count);
    int stop;
    int pick;
    int body;
    stop = word_total + count;
    while (word_total < stop) begin
      pick = $urandom_range(0, 99);
      body = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 20;
      if (pick < 55) begin
        push_frame(body, $urandom_range(0, 4) == 0, FLAW_NONE);
      end else if (pick < 70) begin
        push_frame(body, $urandom_range(0, 4) == 0, flaw_t'($urandom_range(1, 4)));
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 4)) push_word(CMD_BYTE, $urandom);
        push_word(CMD_END, $urandom);
      end else if (pick < 86) begin
        // drop a partial frame on timeout
        repeat ($urandom_range(0, 12)) push_word(CMD_BYTE, $urandom);
        push_word(CMD_TIMEOUT, $urandom);
      end else if (pick < 92) begin
        push_word(CMD_END, $urandom);
      end else if (pick < 96) begin
        repeat ($urandom_range(5, 30)) push_word(CMD_BYTE, $urandom);
        push_word(CMD_END, $urandom);
      end else begin
        push_word(CMD_NONE, $urandom);
      end
    end
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || in_tvalid || pending_replies.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [14:0] v);
    wait_idle();
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset limit
    push_word(CMD_END, 8'h00);
    push_word(CMD_TIMEOUT, 8'hFF);
    push_word(CMD_NONE, 8'hFF);
    push_word(CMD_BYTE, CH_START);
    push_word(CMD_BYTE, "4");
    push_word(CMD_BYTE, "0");
    push_word(CMD_BYTE, CH_STAR);
    push_word(CMD_BYTE, CH_CR);
    push_word(CMD_END, 8'h00);
    push_word(CMD_BYTE, CH_START);
    push_word(CMD_BYTE, CH_STAR);
    push_word(CMD_BYTE, CH_CR);
    push_word(CMD_END, 8'hFF);
    push_word(CMD_BYTE, CH_START);
    push_word(CMD_BYTE, "4");
    push_word(CMD_BYTE, "1");
    push_word(CMD_BYTE, CH_STAR);
    push_word(CMD_BYTE, CH_CR);
    push_word(CMD_END, 8'h00);
    push_frame(5, 1'b1, FLAW_NONE);

    write_limit(15'd0);
    fill_random(150);
    write_limit(15'd20000);
    fill_random(150);
    write_limit(15'($urandom_range(2, 12)));
    fill_random(150);
    write_limit(15'd1);
    fill_random(150);

    // Frames past the byte counter's ceiling
    write_limit(15'($urandom_range(0, 20000)));
    push_frame(290, 1'b0, FLAW_NONE);
    push_frame(260, 1'b0, FLAW_SUM);

    write_limit(15'd0);
    push_word(CMD_TIMEOUT, $urandom);
    push_frame(20, 1'b0, FLAW_NONE);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- ascii_reply_frame_checker.f -----
rtl/core/arfc_pkg.sv
rtl/core/arfc_front.sv
rtl/core/arfc_fifo.sv
rtl/core/arfc_back.sv
rtl/core/ascii_reply_frame_checker.sv
rtl/core/arfc_checker.sv
tb/ascii_reply_frame_checker_test.sv
